@@ hw/rtl/page_free_list_allocator_top_macros.svh @@
// ----------------------------------------------------------------------------
// Page free list allocator assertion macros
// Assertion helpers used by the allocator datapath; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PAGE_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define PAGE_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PFLA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pfla assertion failed");
`define PFLA_NEVER(lbl, clk, rstn, expr) \
    `PFLA_ASSERT(lbl, clk, rstn, !(expr))
`else
`define PFLA_ASSERT(lbl, clk, rstn, prop)
`define PFLA_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ hw/rtl/pfla_pkg.sv @@
// ----------------------------------------------------------------------------
// Page free list allocator package
// Sizes, result codes, controller states and the control bundles.
// ----------------------------------------------------------------------------
package pfla_pkg;

    localparam int MAX_PAGES  = 8192;
    localparam int INIT_PAGES = 2560;
    localparam int INIT_EFF   = (INIT_PAGES > MAX_PAGES) ? MAX_PAGES : INIT_PAGES;

    localparam int PAGE_W  = 13;
    localparam int ADDR_W  = $clog2(MAX_PAGES);
    localparam int COUNT_W = $clog2(MAX_PAGES + 1);
    localparam int CMP_W   = (PAGE_W > COUNT_W) ? PAGE_W : COUNT_W;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADPAGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_GROW,
        S_DELIVER
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic walk_step;
        logic out_load;
        logic out_from_hold;
    } dp_cmd_t;

    typedef struct packed {
        logic grow_start;
        logic walk_last;
        logic out_free;
    } dp_sts_t;

endpackage

@@ hw/rtl/pfla_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/pfla_ctrl.sv @@
// ----------------------------------------------------------------------------
// Page free list allocator controller
// Sequences the initial chain walk, each operation, growth and result delivery.
// ----------------------------------------------------------------------------
module pfla_ctrl import pfla_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT: begin
                if (sts.walk_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (sts.grow_start) begin
                    state_next = S_GROW;
                end else if (sts.out_free) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_DELIVER;
                end
            end
            S_GROW: begin
                if (sts.walk_last) begin
                    state_next = S_DELIVER;
                end
            end
            S_DELIVER: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_comb begin
        s_ready           = 1'b0;
        cmd               = '0;
        case (state_reg)
            S_INIT: begin
                cmd.walk_step = 1'b1;
            end
            S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            S_EXEC: begin
                cmd.exec     = 1'b1;
                cmd.out_load = !sts.grow_start && sts.out_free;
            end
            S_GROW: begin
                cmd.walk_step = 1'b1;
            end
            S_DELIVER: begin
                cmd.out_load      = sts.out_free;
                cmd.out_from_hold = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hw/rtl/pfla_dp.sv @@
// ----------------------------------------------------------------------------
// Page free list allocator datapath
// Link memory, list head, page count, chain walker and the result register.
// ----------------------------------------------------------------------------
`include "page_free_list_allocator_top_macros.svh"

module pfla_dp import pfla_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    input  logic              s_mode,
    input  logic [PAGE_W-1:0] s_free_page,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PAGE_W-1:0] m_page_number,
    output logic [1:0]        m_status
);

    logic                op_mode_reg;
    logic [PAGE_W-1:0]   op_page_reg;
    logic [ADDR_W-1:0]   head_reg;
    logic [ADDR_W-1:0]   head_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [ADDR_W-1:0]   walk_reg;
    logic [ADDR_W-1:0]   walk_next;
    logic [COUNT_W-1:0]  walk_end_reg;
    logic [COUNT_W-1:0]  walk_end_next;
    logic [PAGE_W-1:0]   res_page_reg;
    status_t             res_status_reg;
    logic                m_valid_reg;
    logic [PAGE_W-1:0]   m_page_reg;
    status_t             m_status_reg;

    logic [COUNT_W:0]    count_dbl;
    logic [COUNT_W-1:0]  grown;
    logic [COUNT_W-1:0]  count_inc;
    logic [COUNT_W-1:0]  walk_inc;
    logic                head_empty;
    logic                count_full;
    logic                grow_chain;
    logic                free_ok;
    logic                walk_last;
    logic [PAGE_W-1:0]   res_page_c;
    status_t             res_status_c;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_rdata;

    assign count_dbl  = {count_reg, 1'b0};
    assign grown      = (count_dbl > (COUNT_W+1)'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES)
                                                              : count_dbl[COUNT_W-1:0];
    assign count_inc  = count_reg + COUNT_W'(1);
    assign walk_inc   = COUNT_W'(walk_reg) + COUNT_W'(1);
    assign head_empty = (head_reg == '0);
    assign count_full = (count_reg >= COUNT_W'(MAX_PAGES));
    assign grow_chain = (count_inc < grown);
    assign free_ok    = (op_page_reg != '0) && (CMP_W'(op_page_reg) < CMP_W'(count_reg));
    assign walk_last  = (walk_inc == walk_end_reg);

    assign sts.grow_start = !op_mode_reg && head_empty && !count_full && grow_chain;
    assign sts.walk_last  = walk_last;
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_comb begin
        res_page_c   = '0;
        res_status_c = ST_OK;
        if (!op_mode_reg) begin
            if (!head_empty) begin
                res_page_c = PAGE_W'(head_reg);
            end else if (count_full) begin
                res_status_c = ST_FULL;
            end else begin
                res_page_c = PAGE_W'(count_reg);
            end
        end else if (!free_ok) begin
            res_status_c = ST_BADPAGE;
        end
    end

    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        walk_next     = walk_reg;
        walk_end_next = walk_end_reg;
        if (cmd.walk_step) begin
            walk_next = ADDR_W'(walk_inc);
        end
        if (cmd.exec) begin
            if (!op_mode_reg) begin
                if (!head_empty) begin
                    head_next = ram_rdata;
                end else if (!count_full) begin
                    count_next    = grown;
                    head_next     = grow_chain ? ADDR_W'(count_inc) : '0;
                    walk_next     = ADDR_W'(count_inc);
                    walk_end_next = grown;
                end
            end else if (free_ok) begin
                head_next = ADDR_W'(op_page_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= ADDR_W'(1);
            count_reg    <= COUNT_W'(INIT_EFF);
            walk_reg     <= ADDR_W'(1);
            walk_end_reg <= COUNT_W'(INIT_EFF);
            m_valid_reg  <= 1'b0;
        end else begin
            head_reg     <= head_next;
            count_reg    <= count_next;
            walk_reg     <= walk_next;
            walk_end_reg <= walk_end_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_mode_reg <= s_mode;
            op_page_reg <= s_free_page;
        end
        if (cmd.exec) begin
            res_page_reg   <= res_page_c;
            res_status_reg <= res_status_c;
        end
        if (cmd.out_load) begin
            m_page_reg   <= cmd.out_from_hold ? res_page_reg : res_page_c;
            m_status_reg <= cmd.out_from_hold ? res_status_reg : res_status_c;
        end
    end

    assign ram_we    = cmd.walk_step || (cmd.exec && op_mode_reg && free_ok);
    assign ram_waddr = cmd.walk_step ? walk_reg : ADDR_W'(op_page_reg);
    assign ram_wdata = cmd.walk_step ? (walk_last ? '0 : ADDR_W'(walk_inc)) : head_reg;

    pfla_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_PAGES)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.accept),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign m_valid       = m_valid_reg;
    assign m_page_number = m_page_reg;
    assign m_status      = m_status_reg;

    // The list head always names a page that the table already holds.
    `PFLA_NEVER(a_head_below_count, aclk, aresetn, COUNT_W'(head_reg) >= count_reg)
    `PFLA_NEVER(a_count_max, aclk, aresetn, count_reg > COUNT_W'(MAX_PAGES))
    `PFLA_NEVER(a_count_min, aclk, aresetn, count_reg < COUNT_W'(INIT_EFF))
    `PFLA_ASSERT(a_walk_in_range, aclk, aresetn, cmd.walk_step |-> walk_inc <= walk_end_reg)
    `PFLA_NEVER(a_no_header_write, aclk, aresetn, ram_we && ram_waddr == '0)

endmodule

@@ hw/rtl/page_free_list_allocator_top.sv @@
// An accepted alloc or free beat waits in EXEC for the link memory's registered read;
// EXEC loads the result into the output register if it is free, else DELIVER does, and a
// growing alloc chains the new pages in GROW first. No new beat is accepted until then.
// Reset: synchronous, active low; afterwards a chain walk writes INIT_PAGES-1 link
// entries, one per cycle, and no beat is accepted until it completes.
// ----------------------------------------------------------------------------
// Page free list allocator top level
// LIFO linked free list of table pages with doubling growth on an empty list.
// ----------------------------------------------------------------------------
module page_free_list_allocator_top import pfla_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [PAGE_W-1:0] s_free_page,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PAGE_W-1:0] m_page_number,
    output logic [1:0]        m_status
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    pfla_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pfla_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_mode        (s_mode),
        .s_free_page   (s_free_page),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_page_number (m_page_number),
        .m_status      (m_status)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page free list allocator testbench
// Drives alloc and free beats with random gaps and result stalls. Each result is
// checked against a cycle-free model of the linked free list that grows on an
// empty list, or, for its typed rows, against the directed table that comes first.
// A drain phase follows, mostly allocs, that runs the store through both growth steps
// into the full state. A mixed phase closes the run and also frees pages twice.
// ----------------------------------------------------------------------------
module tb import pfla_pkg::*; ();

    localparam int CLK_HIGH            = 6;
    localparam int CLK_LOW             = 6;
    localparam int RESET_CYCLES        = 10;
    localparam int CYCLE_LIMIT         = 3_000_000;
    localparam int DRAIN_CYCLES        = 16;
    localparam int DRAIN_BEAT_CAP      = 20000;
    localparam int FULL_HITS_WANTED    = 3;
    localparam int MIXED_BEATS         = 1200;
    localparam int MISMATCH_REPORT_MAX = 10;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        status_t           status;
    } page_result_t;

    typedef struct packed {
        logic              mode;
        logic [PAGE_W-1:0] page;
        logic              typed;
        logic [PAGE_W-1:0] exp_page;
        status_t           exp_status;
    } dir_row_t;

    localparam int DIRECTED_COUNT = 21;
    localparam dir_row_t DIRECTED_BEATS [DIRECTED_COUNT] = '{
        '{MODE_ALLOC, 13'd0,    1'b1, 13'd1, ST_OK},
        '{MODE_ALLOC, 13'd8191, 1'b1, 13'd2, ST_OK},
        '{MODE_FREE,  13'd0,    1'b1, 13'd0, ST_BADPAGE},
        '{MODE_FREE,  13'd2560, 1'b1, 13'd0, ST_BADPAGE},
        '{MODE_FREE,  13'd8191, 1'b1, 13'd0, ST_BADPAGE},
        '{MODE_FREE,  13'd1,    1'b1, 13'd0, ST_OK},
        '{MODE_ALLOC, 13'd5461, 1'b1, 13'd1, ST_OK},
        '{MODE_FREE,  13'd2,    1'b1, 13'd0, ST_OK},
        '{MODE_FREE,  13'd1,    1'b1, 13'd0, ST_OK},
        '{MODE_ALLOC, 13'd2730, 1'b1, 13'd1, ST_OK},
        '{MODE_ALLOC, 13'd0,    1'b1, 13'd2, ST_OK},
        '{MODE_ALLOC, 13'd0,    1'b1, 13'd3, ST_OK},
        '{MODE_ALLOC, 13'd4095, 1'b0, 13'd0, ST_OK},
        '{MODE_FREE,  13'd4096, 1'b1, 13'd0, ST_BADPAGE},
        '{MODE_FREE,  13'd2561, 1'b1, 13'd0, ST_BADPAGE},
        '{MODE_FREE,  13'd3,    1'b0, 13'd0, ST_OK},
        '{MODE_FREE,  13'd4,    1'b0, 13'd0, ST_OK},
        '{MODE_ALLOC, 13'd0,    1'b0, 13'd0, ST_OK},
        '{MODE_FREE,  13'd2,    1'b0, 13'd0, ST_OK},
        '{MODE_ALLOC, 13'd0,    1'b0, 13'd0, ST_OK},
        '{MODE_ALLOC, 13'd0,    1'b0, 13'd0, ST_OK}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_mode;
    logic [PAGE_W-1:0] s_free_page;
    logic              m_valid;
    logic              m_ready;
    logic [PAGE_W-1:0] m_page_number;
    logic [1:0]        m_status;

    page_result_t page_result_q [$];
    int           mismatch_count;
    int           cycle_count;
    int           gap_burst_left;

    logic [PAGE_W-1:0] link_mem [0:MAX_PAGES-1];
    logic [PAGE_W-1:0] free_head;
    int                table_pages;

    logic [PAGE_W-1:0] held_pages [$];
    bit                page_out [0:MAX_PAGES-1];
    logic [PAGE_W-1:0] last_freed;

    page_free_list_allocator_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_free_page   (s_free_page),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_page_number (m_page_number),
        .m_status      (m_status)
    );

    initial aclk = 1'b0;
    always begin
        #CLK_LOW  aclk = 1'b1;
        #CLK_HIGH aclk = 1'b0;
    end

    function automatic void chain_range(int first, int last_end);
        if (first >= last_end || last_end > MAX_PAGES) begin
            return;
        end
        for (int p = first; p + 1 < last_end; p++) begin
            link_mem[p] = PAGE_W'(p + 1);
        end
        link_mem[last_end - 1] = '0;
    endfunction

    function automatic void reset_page_table();
        for (int p = 0; p < MAX_PAGES; p++) begin
            link_mem[p] = '0;
            page_out[p] = 1'b0;
        end
        chain_range(1, INIT_EFF);
        free_head   = (INIT_EFF > 1) ? PAGE_W'(1) : '0;
        table_pages = INIT_EFF;
    endfunction

    function automatic page_result_t predict_page_result(logic mode, logic [PAGE_W-1:0] page);
        page_result_t r;
        int           n;
        int           grown;
        r.page_number = '0;
        r.status      = ST_OK;
        if (mode == MODE_ALLOC) begin
            if (free_head != '0) begin
                r.page_number = free_head;
                free_head     = link_mem[free_head];
            end else if (table_pages >= MAX_PAGES) begin
                r.status = ST_FULL;
            end else begin
                n     = table_pages;
                grown = (2 * n > MAX_PAGES) ? MAX_PAGES : 2 * n;
                r.page_number = PAGE_W'(n);
                chain_range(n + 1, grown);
                free_head   = (n + 1 < grown) ? PAGE_W'(n + 1) : '0;
                table_pages = grown;
            end
        end else begin
            if (page == '0 || int'(page) >= table_pages) begin
                r.status = ST_BADPAGE;
            end else begin
                link_mem[page] = free_head;
                free_head      = page;
            end
        end
        return r;
    endfunction

    function automatic void track_holdings(logic mode, logic [PAGE_W-1:0] page,
                                           page_result_t res);
        if (res.status != ST_OK) begin
            return;
        end
        if (mode == MODE_ALLOC) begin
            if (!page_out[res.page_number]) begin
                page_out[res.page_number] = 1'b1;
                held_pages.push_back(res.page_number);
            end
        end else begin
            last_freed = page;
            if (page_out[page]) begin
                page_out[page] = 1'b0;
                for (int i = 0; i < held_pages.size(); i++) begin
                    if (held_pages[i] == page) begin
                        held_pages[i] = held_pages[held_pages.size() - 1];
                        held_pages.pop_back();
                        break;
                    end
                end
            end
        end
    endfunction

    function automatic logic [PAGE_W-1:0] pick_held_page();
        return held_pages[$urandom_range(0, held_pages.size() - 1)];
    endfunction

    function automatic int pick_gap();
        int r;
        if (gap_burst_left > 0) begin
            gap_burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            gap_burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic void report_mismatch(string what, page_result_t want,
                                            logic [PAGE_W-1:0] got_page, logic [1:0] got_status);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_REPORT_MAX) begin
            $display("tb: %s at cycle %0d: expected page %0d status %0d, got page %0d status %0d",
                     what, cycle_count, want.page_number, want.status, got_page, got_status);
        end
    endfunction

    // One beat on the request side; the model is stepped at the accepting edge.
    task automatic send_beat(input logic mode, input logic [PAGE_W-1:0] page,
                             input logic typed, input page_result_t typed_res,
                             output page_result_t predicted);
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_free_page <= page;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        predicted = predict_page_result(mode, page);
        page_result_q.push_back(typed ? typed_res : predicted);
        track_holdings(mode, page, predicted);
    endtask

    task automatic idle_before_next();
        int g;
        g = pick_gap();
        if (g > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        page_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (page_result_q.size() == 0) begin
                want = '0;
                report_mismatch("unexpected result", want, m_page_number, m_status);
            end else begin
                want = page_result_q.pop_front();
                if (m_page_number !== want.page_number || m_status !== 2'(want.status)) begin
                    report_mismatch("result mismatch", want, m_page_number, m_status);
                end
            end
        end
    end

    initial begin
        int run;
        int stall;
        int r;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
            repeat (run) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
            r = $urandom_range(0, 99);
            stall = (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 4) : $urandom_range(8, 24);
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin
        page_result_t got;
        page_result_t typed_res;
        logic [PAGE_W-1:0] page;
        logic mode;
        int full_hits;
        int beats;
        int r;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_mode         = MODE_ALLOC;
        s_free_page    = '0;
        m_ready        = 1'b0;
        mismatch_count = 0;
        gap_burst_left = 0;
        last_freed     = '0;
        full_hits      = 0;
        beats          = 0;
        reset_page_table();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            typed_res.page_number = DIRECTED_BEATS[i].exp_page;
            typed_res.status      = DIRECTED_BEATS[i].exp_status;
            send_beat(DIRECTED_BEATS[i].mode, DIRECTED_BEATS[i].page,
                      DIRECTED_BEATS[i].typed, typed_res, got);
            idle_before_next();
        end

        // Drain the list through both growth steps; frees name only held or bad pages,
        // since a page freed twice closes the list into a loop that never empties.
        typed_res = '0;
        while (full_hits < FULL_HITS_WANTED && beats < DRAIN_BEAT_CAP) begin
            if ($urandom_range(0, 99) < 88) begin
                mode = MODE_ALLOC;
                page = PAGE_W'($urandom);
            end else begin
                mode = MODE_FREE;
                if (held_pages.size() > 0 && $urandom_range(0, 99) < 65) begin
                    page = pick_held_page();
                end else if (table_pages >= MAX_PAGES || $urandom_range(0, 3) == 0) begin
                    page = '0;
                end else begin
                    page = PAGE_W'($urandom_range(table_pages, MAX_PAGES - 1));
                end
            end
            send_beat(mode, page, 1'b0, typed_res, got);
            if (got.status == ST_FULL) full_hits++;
            beats++;
            idle_before_next();
        end

        repeat (MIXED_BEATS) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                mode = MODE_ALLOC;
                page = PAGE_W'($urandom);
            end else begin
                mode = MODE_FREE;
                r = $urandom_range(0, 99);
                if (r < 75 && held_pages.size() > 0) begin
                    page = pick_held_page();
                end else if (r < 92) begin
                    page = PAGE_W'($urandom);
                end else begin
                    page = last_freed;
                end
            end
            send_beat(mode, page, 1'b0, typed_res, got);
            idle_before_next();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (page_result_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && page_result_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
